### rtl/next_fit_slot_table_macros.svh
// Assertion macros for the next-fit slot table.
// Used by next_fit_slot_table.sv; expects i_clk and i_rst_n in scope.
`ifndef NEXT_FIT_SLOT_TABLE_MACROS_SVH
`define NEXT_FIT_SLOT_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NFST_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NFST_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/nfst_pkg.sv
// Shared types and codes for the next-fit slot table.
// No dependencies; imported by next_fit_slot_table.
`default_nettype none

package nfst_pkg;

    localparam int SLOT_W = 10;
    localparam int ID_W   = 16;
    localparam int PAY_W  = 48;
    localparam int CMD_W  = 3;
    localparam int MAIN_W = 10;
    localparam int CNT_W  = 11;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [CNT_W-1:0]  t_cur;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [0:0]        t_cfg_idx;
    typedef logic              t_status;

    localparam t_cmd CMD_READ       = 3'd0;
    localparam t_cmd CMD_WRITE      = 3'd1;
    localparam t_cmd CMD_CLEAR      = 3'd2;
    localparam t_cmd CMD_ALLOC_MAIN = 3'd3;
    localparam t_cmd CMD_ALLOC_EXT  = 3'd4;

    localparam t_status ST_OK   = 1'b0;
    localparam t_status ST_FAIL = 1'b1;

    localparam t_cfg_idx CFG_MAIN_COUNT  = 1'b0;
    localparam t_cfg_idx CFG_TOTAL_COUNT = 1'b1;

endpackage

`default_nettype wire

### rtl/nfst_ram.sv
// Generic single-port RAM with a registered read, read-first on a write.
// No dependencies; used for the id and payload stores.
`default_nettype none

module nfst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/next_fit_slot_table.sv
// Top level of the next-fit slot table: control sequencer, cursors, config
// registers and output register. Depends on nfst_pkg, nfst_ram and the macro header.
`default_nettype none

// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+----------------------------------
// input     | in        | i_in_valid / o_in_stall    | i_cmd, i_entry_slot, i_entry_id,
//           |           |                            | i_entry_payload
// result    | out       | o_out_valid / i_out_stall  | o_status, o_found_slot,
//           |           |                            | o_read_id, o_read_payload
// config    | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Steps: write, clear and rejected items pass the execute and finish states on the way to the
// output register; a read also passes a read-wait state in between. An allocation walks the
// id memory one slot per cycle through its single read port, over up to two passes of its
// region when nothing is free.
// Reset: after reset the id memory is swept to zero, one entry per cycle; o_in_stall stays
// high during the sweep. Config writes are always taken.
// Stalls: a finished item waits in the output register; a new item is accepted while it
// waits, and its result is held until the output register frees up.

`include "next_fit_slot_table_macros.svh"

module next_fit_slot_table
    import nfst_pkg::*;
#(
    parameter int TABLE_DEPTH  = 1024,
    parameter int PAYLOAD_BITS = 48
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Input item channel.
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [CMD_W-1:0]  i_cmd,
    input  wire logic [SLOT_W-1:0] i_entry_slot,
    input  wire logic [ID_W-1:0]   i_entry_id,
    input  wire logic [PAY_W-1:0]  i_entry_payload,
    // Result channel.
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_status,
    output logic      [SLOT_W-1:0] o_found_slot,
    output logic      [ID_W-1:0]   o_read_id,
    output logic      [PAY_W-1:0]  o_read_payload,
    // Configuration write channel.
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [0:0]        i_cfg_index,
    input  wire logic [CNT_W-1:0]  i_cfg_data
);

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int KEEP = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;
    localparam logic [31:0]   DEPTH_U   = TABLE_DEPTH;
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

    // Sequencer states.
    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_RDWAIT = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [AW-1:0]     r_clr_addr, n_clr_addr;

    // Configuration registers.
    logic [MAIN_W-1:0] r_main_count;
    t_cur              r_total_count;

    // Captured item.
    t_cmd              r_cmd;
    t_slot             r_slot;
    logic [ID_W-1:0]   r_id;
    logic [PAY_W-1:0]  r_pay;

    // Cursors and scan pipeline.
    t_cur              r_main_cur, n_main_cur;
    t_cur              r_ext_cur, n_ext_cur;
    t_cur              r_ptr, n_ptr;
    t_cur              r_chk_addr, n_chk_addr;
    logic              r_chk_v, n_chk_v;
    logic              r_pass, n_pass;

    // Finished result waiting for the output register.
    t_status           r_res_status, n_res_status;
    t_slot             r_res_found, n_res_found;
    logic [ID_W-1:0]   r_res_id, n_res_id;
    logic [PAY_W-1:0]  r_res_pay, n_res_pay;

    // Output register.
    logic              r_out_valid, n_out_valid;
    t_status           r_out_status;
    t_slot             r_out_found;
    logic [ID_W-1:0]   r_out_id;
    logic [PAY_W-1:0]  r_out_pay;

    // Memory ports.
    logic                    id_we;
    logic [AW-1:0]           id_addr;
    logic [ID_W-1:0]         id_wdata;
    logic [ID_W-1:0]         id_rdata;
    logic                    pay_we;
    logic [PAYLOAD_BITS-1:0] pay_wdata;
    logic [PAYLOAD_BITS-1:0] pay_rdata;

    logic    w_in_acc;
    logic    w_out_load;
    logic    w_slot_ok;
    logic    w_is_main;
    t_cur    w_main_end;
    t_cur    w_lo;
    t_cur    w_hi;
    t_cur    w_cur;
    t_cur    w_start;
    t_cur    w_chk_next;
    logic    w_chk_free;
    logic    w_cur_we;
    t_cur    w_cur_val;
    logic [PAYLOAD_BITS-1:0] w_pay_in;

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // The main region is [1, main_count+1), the extended one [main_count+1, total_count).
    assign w_is_main  = (r_cmd == CMD_ALLOC_MAIN);
    assign w_main_end = {1'b0, r_main_count} + 11'd1;
    assign w_lo       = w_is_main ? 11'd1 : w_main_end;
    assign w_hi       = w_is_main ? w_main_end : r_total_count;
    assign w_cur      = w_is_main ? r_main_cur : r_ext_cur;
    // A cursor outside its region restarts at the region start.
    assign w_start    = (w_cur < w_lo || w_cur >= w_hi) ? w_lo : w_cur;

    assign w_slot_ok  = (r_slot != '0) && ({22'd0, r_slot} < DEPTH_U);
    // Slots past the end of the table count as occupied.
    assign w_chk_free = r_chk_v && (id_rdata == '0) && ({21'd0, r_chk_addr} < DEPTH_U);
    assign w_chk_next = r_chk_addr + 11'd1;
    assign w_pay_in   = PAYLOAD_BITS'(r_pay[KEEP-1:0]);

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_main_cur   = r_main_cur;
        n_ext_cur    = r_ext_cur;
        n_ptr        = r_ptr;
        n_chk_addr   = r_chk_addr;
        n_chk_v      = r_chk_v;
        n_pass       = r_pass;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_res_id     = r_res_id;
        n_res_pay    = r_res_pay;
        n_out_valid  = r_out_valid && i_out_stall;
        w_out_load   = 1'b0;
        w_cur_we     = 1'b0;
        w_cur_val    = r_ptr;
        id_we        = 1'b0;
        id_addr      = AW'(r_ptr);
        id_wdata     = '0;
        pay_we       = 1'b0;
        pay_wdata    = '0;

        unique case (r_state)
            S_CLEAR: begin
                id_we      = 1'b1;
                id_addr    = r_clr_addr;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                id_addr      = AW'(r_slot);
                n_res_status = ST_FAIL;
                n_res_found  = '0;
                n_res_id     = '0;
                n_res_pay    = '0;
                n_state      = S_FIN;
                unique case (r_cmd)
                    CMD_READ: begin
                        // The read is issued this cycle; data lands next cycle.
                        if (w_slot_ok) begin
                            n_state = S_RDWAIT;
                        end
                    end
                    CMD_WRITE: begin
                        if (w_slot_ok) begin
                            id_we        = 1'b1;
                            id_wdata     = r_id;
                            pay_we       = 1'b1;
                            pay_wdata    = w_pay_in;
                            n_res_status = ST_OK;
                        end
                    end
                    CMD_CLEAR: begin
                        if (w_slot_ok) begin
                            id_we        = 1'b1;
                            pay_we       = 1'b1;
                            n_res_status = ST_OK;
                        end
                    end
                    CMD_ALLOC_MAIN, CMD_ALLOC_EXT: begin
                        if (w_lo >= w_hi) begin
                            // Empty region: the cursor parks at the region start.
                            w_cur_we  = 1'b1;
                            w_cur_val = w_lo;
                        end else begin
                            n_ptr   = w_start;
                            n_pass  = 1'b0;
                            n_chk_v = 1'b0;
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_RDWAIT: begin
                n_res_status = ST_OK;
                n_res_id     = id_rdata;
                n_res_pay    = PAY_W'(pay_rdata[KEEP-1:0]);
                n_state      = S_FIN;
            end
            S_SCAN: begin
                priority if (w_chk_free) begin
                    // Found: the cursor moves one past, wrapping to the start at the end.
                    n_res_status = ST_OK;
                    n_res_found  = SLOT_W'(r_chk_addr);
                    w_cur_we     = 1'b1;
                    w_cur_val    = (w_chk_next >= w_hi) ? w_lo : w_chk_next;
                    n_chk_v      = 1'b0;
                    n_state      = S_FIN;
                end else if (r_ptr < w_hi) begin
                    n_ptr      = r_ptr + 11'd1;
                    n_chk_addr = r_ptr;
                    n_chk_v    = 1'b1;
                end else if (!r_pass) begin
                    // End of the first pass: wrap and scan the whole region once more.
                    n_ptr   = w_lo;
                    n_pass  = 1'b1;
                    n_chk_v = 1'b0;
                end else begin
                    n_chk_v   = 1'b0;
                    w_cur_we  = 1'b1;
                    w_cur_val = w_hi;
                    n_state   = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_out_load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_cur_we) begin
            if (w_is_main) begin
                n_main_cur = w_cur_val;
            end else begin
                n_ext_cur = w_cur_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_main_cur    <= 11'd1;
            r_ext_cur     <= '0;
            r_ptr         <= '0;
            r_chk_addr    <= '0;
            r_chk_v       <= 1'b0;
            r_pass        <= 1'b0;
            r_out_valid   <= 1'b0;
            r_main_count  <= '0;
            r_total_count <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_main_cur  <= n_main_cur;
            r_ext_cur   <= n_ext_cur;
            r_ptr       <= n_ptr;
            r_chk_addr  <= n_chk_addr;
            r_chk_v     <= n_chk_v;
            r_pass      <= n_pass;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_MAIN_COUNT:  r_main_count  <= i_cfg_data[MAIN_W-1:0];
                    CFG_TOTAL_COUNT: r_total_count <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd  <= i_cmd;
            r_slot <= i_entry_slot;
            r_id   <= i_entry_id;
            r_pay  <= i_entry_payload;
        end
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_res_id     <= n_res_id;
        r_res_pay    <= n_res_pay;
        if (w_out_load) begin
            r_out_status <= r_res_status;
            r_out_found  <= r_res_found;
            r_out_id     <= r_res_id;
            r_out_pay    <= r_res_pay;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_found_slot   = r_out_found;
    assign o_read_id      = r_out_id;
    assign o_read_payload = r_out_pay;

    nfst_ram #(
        .WIDTH (ID_W),
        .DEPTH (TABLE_DEPTH)
    ) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (id_we),
        .i_addr  (id_addr),
        .i_wdata (id_wdata),
        .o_rdata (id_rdata)
    );

    nfst_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (pay_we),
        .i_addr  (AW'(r_slot)),
        .i_wdata (pay_wdata),
        .o_rdata (pay_rdata)
    );

    // An accepted item always enters the execute step next.
    `NFST_ASSERT_NXT(a_accept_exec, w_in_acc, r_state == S_EXEC, "accept did not start execute")
    // The slot under check is always behind the issue pointer.
    `NFST_ASSERT_IMP(a_chk_behind, r_chk_v, r_chk_addr < r_ptr, "check address not behind pointer")
    // The main cursor never points at the reserved slot zero.
    `NFST_ASSERT_IMP(a_main_cur_nz, 1'b1, r_main_cur != '0, "main cursor reached slot zero")

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for next_fit_slot_table: directed and random items checked
// against an in-bench slot table predictor. Depends on nfst_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb;
    import nfst_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int HALF_PERIOD = 5;
    // The slowest item is an allocation that scans its region twice, and the sweep after reset
    // clears every entry of the table. Add the longest gap and stall on each side, then take
    // that several times over.
    localparam int QUIET_LIMIT = 10000;

    // Command codes the block must reject.
    localparam t_cmd CMD_BAD_FIRST = 3'd5;
    localparam t_cmd CMD_BAD_LAST  = 3'd7;

    // One answer of the slot table, as the result channel carries it.
    typedef struct packed {
        t_status           status;
        t_slot             found;
        logic [ID_W-1:0]   id;
        logic [PAY_W-1:0]  payload;
    } t_slot_answer;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [CMD_W-1:0]   i_cmd;
    logic [SLOT_W-1:0]  i_entry_slot;
    logic [ID_W-1:0]    i_entry_id;
    logic [PAY_W-1:0]   i_entry_payload;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_status;
    logic [SLOT_W-1:0]  o_found_slot;
    logic [ID_W-1:0]    o_read_id;
    logic [PAY_W-1:0]   o_read_payload;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [0:0]         i_cfg_index;
    logic [CNT_W-1:0]   i_cfg_data;

    next_fit_slot_table #(
        .TABLE_DEPTH (DEPTH),
        .PAYLOAD_BITS(PAY_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_entry_slot   (i_entry_slot),
        .i_entry_id     (i_entry_id),
        .i_entry_payload(i_entry_payload),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_found_slot   (o_found_slot),
        .o_read_id      (o_read_id),
        .o_read_payload (o_read_payload),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Shadow copy of the slot table. Payloads that were never written or cleared are
    // tracked so that the stimulus never reads one back.
    logic [ID_W-1:0]  tbl_id  [DEPTH];
    logic [PAY_W-1:0] tbl_pay [DEPTH];
    bit               pay_known [DEPTH];
    int               known_slots[$];
    int               main_next;
    int               ext_next;
    int               cfg_main;
    int               cfg_total;
    t_slot            last_found;

    // Answers still owed by the block, oldest first.
    t_slot_answer     slot_answers[$];
    int               mismatches;
    int               quiet_cycles;
    // While set, neither side idles, so items go back to back.
    bit               calm;

    // Next-fit search over one region. Each of the two passes first pulls a cursor that
    // lies outside the region back to its start; the cursor ends one past the find.
    function automatic t_slot next_fit(input bit extended);
        int cur;
        int lo;
        int hi;
        int hit;
        cur = extended ? ext_next : main_next;
        lo  = extended ? cfg_main + 1 : 1;
        hi  = extended ? cfg_total : cfg_main + 1;
        hit = 0;
        for (int pass = 0; pass < 2; pass++) begin
            if (cur < lo || cur >= hi) cur = lo;
            while (cur < hi && hit == 0) begin
                // Slots past the end of the table count as occupied.
                if (cur < DEPTH && tbl_id[cur] == '0) hit = cur;
                cur++;
            end
        end
        if (extended) ext_next = cur;
        else main_next = cur;
        return t_slot'(hit);
    endfunction

    // Applies one accepted item to the shadow table and returns the answer it causes.
    function automatic t_slot_answer predict_slot_answer(input t_cmd cmd, input t_slot slot,
                                                         input logic [ID_W-1:0] id,
                                                         input logic [PAY_W-1:0] pay);
        t_slot_answer ans;
        bit           in_range;
        ans = '0;
        ans.status = ST_FAIL;
        in_range = (slot != '0) && (int'(slot) < DEPTH);
        case (cmd)
            CMD_READ: begin
                if (in_range) begin
                    ans.status  = ST_OK;
                    ans.id      = tbl_id[slot];
                    ans.payload = tbl_pay[slot];
                end
            end
            CMD_WRITE, CMD_CLEAR: begin
                if (in_range) begin
                    ans.status    = ST_OK;
                    tbl_id[slot]  = (cmd == CMD_WRITE) ? id : '0;
                    tbl_pay[slot] = (cmd == CMD_WRITE) ? pay : '0;
                    if (!pay_known[slot]) begin
                        pay_known[slot] = 1'b1;
                        known_slots.push_back(int'(slot));
                    end
                end
            end
            CMD_ALLOC_MAIN, CMD_ALLOC_EXT: begin
                ans.found  = next_fit(cmd == CMD_ALLOC_EXT);
                ans.status = (ans.found != '0) ? ST_OK : ST_FAIL;
                last_found = ans.found;
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offers one item after an optional gap and holds it until the block takes it. The
    // answer is predicted at the edge where the item is accepted.
    task automatic send_item(input t_cmd cmd, input t_slot slot, input logic [ID_W-1:0] id,
                             input logic [PAY_W-1:0] pay);
        int gap;
        gap = calm ? 0 : pick_pause();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid      = 1'b1;
        i_cmd           = cmd;
        i_entry_slot    = slot;
        i_entry_id      = id;
        i_entry_payload = pay;
        do @(posedge i_clk); while (o_in_stall);
        slot_answers.push_back(predict_slot_answer(cmd, slot, id, pay));
    endtask

    // Stops offering items and waits until every owed answer has come back. Each item
    // causes exactly one answer, so the block is idle afterwards.
    task automatic drain_items();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (slot_answers.size() != 0) @(posedge i_clk);
    endtask

    // Writes one configuration register and mirrors it into the predictor.
    task automatic write_reg(input t_cfg_idx idx, input int value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value[CNT_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_MAIN_COUNT) cfg_main = int'(value[MAIN_W-1:0]);
        else cfg_total = int'(value[CNT_W-1:0]);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Empty regions, rejected commands and slot zero, right after reset.
    task automatic test_reset_defaults();
        write_reg(CFG_MAIN_COUNT, 0);
        write_reg(CFG_TOTAL_COUNT, 0);
        send_item(CMD_ALLOC_MAIN, '0, '0, '0);
        send_item(CMD_ALLOC_EXT, '0, '0, '0);
        for (int c = CMD_BAD_FIRST; c <= CMD_BAD_LAST; c++) begin
            send_item(t_cmd'(c), '1, '1, '1);
        end
        send_item(CMD_READ, '0, '0, '0);
        send_item(CMD_WRITE, '0, '1, '1);
        send_item(CMD_CLEAR, '0, '0, '0);
    endtask

    // Write and read back at both ends of the valid slot range, and clear at the top end.
    task automatic test_slot_access();
        send_item(CMD_WRITE, 10'd1, '1, '1);
        send_item(CMD_READ, 10'd1, '0, '0);
        send_item(CMD_WRITE, '1, 16'h0001, '0);
        send_item(CMD_READ, '1, '0, '0);
        send_item(CMD_CLEAR, '1, '1, '1);
        send_item(CMD_READ, '1, '0, '0);
    endtask

    // Cursor wrap in both regions, a find on the last slot of a region, a region that
    // starts at the end of the table, and an extended region that ends before it starts.
    task automatic test_next_fit_search();
        drain_items();
        write_reg(CFG_MAIN_COUNT, 3);
        write_reg(CFG_TOTAL_COUNT, 6);
        send_item(CMD_WRITE, 10'd2, 16'h0005, 48'h0000_1234_5678);
        repeat (3) send_item(CMD_ALLOC_MAIN, '0, '0, '0);
        repeat (3) send_item(CMD_ALLOC_EXT, '0, '0, '0);
        drain_items();
        write_reg(CFG_MAIN_COUNT, DEPTH - 1);
        write_reg(CFG_TOTAL_COUNT, DEPTH);
        send_item(CMD_ALLOC_EXT, '0, '0, '0);
        send_item(CMD_ALLOC_MAIN, '0, '0, '0);
        drain_items();
        write_reg(CFG_MAIN_COUNT, 5);
        write_reg(CFG_TOTAL_COUNT, 2);
        send_item(CMD_ALLOC_EXT, '0, '0, '0);
    endtask

    // Phases of random traffic, each under its own region sizes. Most items follow the
    // normal flow: allocate, then claim the found slot with a nonzero id, so that regions
    // fill up and later searches wrap and fail. Clears free slots again; reads go to slots
    // whose payload is known, or to slot zero.
    task automatic test_random_traffic();
        t_cmd             cmd;
        t_slot            slot;
        logic [ID_W-1:0]  id;
        logic [PAY_W-1:0] pay;
        int               main_n;
        int               total_n;
        int               reach;
        int               r;
        bit               have_claim;
        t_slot            claim;
        have_claim = 1'b0;
        claim = '0;
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                3: begin
                    main_n  = DEPTH - 1;
                    total_n = DEPTH;
                end
                6: begin
                    main_n  = $urandom_range(300, 900);
                    total_n = DEPTH;
                end
                8: begin
                    main_n  = 0;
                    total_n = $urandom_range(2, 12);
                end
                default: begin
                    main_n  = $urandom_range(1, 10);
                    total_n = main_n + 1 + $urandom_range(0, 10);
                    if ($urandom_range(0, 5) == 0) total_n = $urandom_range(0, main_n);
                end
            endcase
            drain_items();
            write_reg(CFG_MAIN_COUNT, main_n);
            write_reg(CFG_TOTAL_COUNT, total_n);
            calm = (phase % 3 == 1);
            have_claim = 1'b0;
            // Slots near the regions, so that writes and clears meet the searches.
            reach = (cfg_total > cfg_main + 1) ? cfg_total : cfg_main + 1;
            if (reach > DEPTH - 1) reach = DEPTH - 1;
            for (int k = 0; k < 27; k++) begin
                r    = $urandom_range(0, 99);
                id   = ID_W'($urandom);
                pay  = PAY_W'({$urandom, $urandom});
                slot = ($urandom_range(0, 9) < 7) ? t_slot'($urandom_range(1, reach))
                                                  : t_slot'($urandom);
                if ($urandom_range(0, 9) == 0) pay = '1;
                else if ($urandom_range(0, 9) == 0) pay = '0;
                if ($urandom_range(0, 19) == 0) id = '1;
                if (have_claim && r < 60) begin
                    cmd  = CMD_WRITE;
                    slot = claim;
                    if (id == '0 || $urandom_range(0, 19) != 0) id = id | 16'h0001;
                end else if (r < 30) begin
                    cmd = CMD_ALLOC_MAIN;
                end else if (r < 55) begin
                    cmd = CMD_ALLOC_EXT;
                end else if (r < 70) begin
                    cmd = CMD_WRITE;
                end else if (r < 82) begin
                    cmd = CMD_CLEAR;
                end else if (r < 96) begin
                    cmd = CMD_READ;
                    if (known_slots.size() != 0 && $urandom_range(0, 9) != 0)
                        slot = t_slot'(known_slots[$urandom_range(0, known_slots.size() - 1)]);
                    else
                        slot = '0;
                end else begin
                    cmd = t_cmd'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST));
                end
                if (cmd == CMD_WRITE && slot == claim) have_claim = 1'b0;
                send_item(cmd, slot, id, pay);
                if ((cmd == CMD_ALLOC_MAIN || cmd == CMD_ALLOC_EXT) && last_found != '0) begin
                    have_claim = 1'b1;
                    claim = last_found;
                end
            end
        end
        calm = 1'b0;
    endtask

    // Result side: the stall toggles in runs of random length, and stays low while calm.
    initial begin
        int run;
        int n;
        run = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (run > 0) begin
                run--;
            end else if (calm || i_out_stall) begin
                i_out_stall = 1'b0;
                run = calm ? 0 : $urandom_range(0, 7);
            end else begin
                n = pick_pause();
                i_out_stall = (n != 0);
                run = (n != 0) ? n - 1 : 0;
            end
        end
    end

    // Each accepted result is held against the oldest owed answer, field by field.
    always @(posedge i_clk) begin : check_results
        t_slot_answer want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (slot_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d slot %0d id %h payload %h",
                             o_status, o_found_slot, o_read_id, o_read_payload);
            end else begin
                want = slot_answers.pop_front();
                if (o_status !== want.status || o_found_slot !== want.found ||
                    o_read_id !== want.id || o_read_payload !== want.payload) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected status %0d slot %0d id %h payload %h,",
                                  " got status %0d slot %0d id %h payload %h"},
                                 want.status, want.found, want.id, want.payload,
                                 o_status, o_found_slot, o_read_id, o_read_payload);
                end
            end
        end
    end

    // Watchdog: ends the run when no channel has moved anything for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("next_fit_slot_table test failed");
            $finish;
        end
    end

    initial begin
        for (int s = 0; s < DEPTH; s++) begin
            tbl_id[s]    = '0;
            tbl_pay[s]   = '0;
            pay_known[s] = 1'b0;
        end
        main_next       = 1;
        ext_next        = 0;
        cfg_main        = 0;
        cfg_total       = 0;
        last_found      = '0;
        mismatches      = 0;
        quiet_cycles    = 0;
        calm            = 1'b0;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_cmd           = CMD_READ;
        i_entry_slot    = '0;
        i_entry_id      = '0;
        i_entry_payload = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_MAIN_COUNT;
        i_cfg_data      = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_slot_access();
        test_next_fit_search();
        test_random_traffic();

        // Once every answer is in, keep watching the result channel for a stray result.
        drain_items();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && slot_answers.size() == 0)
            $display("next_fit_slot_table test passed");
        else
            $display("next_fit_slot_table test failed");
        $finish;
    end

endmodule
